>>> hdl/dsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the directional 3x3 smoothing filter.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int ROW_W       = 11;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_DIM     = 3;
    localparam int RESET_DIM   = 512;
    localparam int DIR_W       = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = CFG_INDEX_W'(0),
        REG_FRAME_HEIGHT = CFG_INDEX_W'(1)
    } cfg_reg_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_VERTICAL,
        DIR_HORIZONTAL,
        DIR_DIAG_MAIN,
        DIR_DIAG_ANTI,
        DIR_BORDER
    } dir_t;

    // Per-item control that travels down the pipeline next to the data
    typedef struct packed {
        logic emit;
        logic tail;
        logic interior;
        logic last;
    } tag_t;

endpackage
`default_nettype wire

>>> hdl/dsm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_if
// Valid/ready channels of the smoothing filter: pixel input, result output
// and configuration writes.
// ----------------------------------------------------------------------------
interface dsm_pixel_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface dsm_result_if import dsm_pkg::*; #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic [DIR_W-1:0]      direction;
    logic                  last;

    modport source (output valid, output pixel_out, output direction, output last,
                    input ready);
    modport sink   (input valid, input pixel_out, input direction, input last,
                    output ready);
endinterface

interface dsm_cfg_if import dsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/dsm_line_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_line_buf
// Two line banks, one per row parity, read together at one column with
// registered read data; one bank written per cycle.
// ----------------------------------------------------------------------------
module dsm_line_buf #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  PIXEL_BITS = 8,
    localparam int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [COL_W-1:0]      addr,
    input  logic                  wr_en,
    input  logic                  wr_bank,
    input  logic [PIXEL_BITS-1:0] wr_data,
    output logic [PIXEL_BITS-1:0] rd_data0,
    output logic [PIXEL_BITS-1:0] rd_data1
);

    logic [PIXEL_BITS-1:0] bank0_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] bank1_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd0_reg;
    logic [PIXEL_BITS-1:0] rd1_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg <= bank0_mem[addr];
            rd1_reg <= bank1_mem[addr];
        end
        if (wr_en && !wr_bank)
        begin
            bank0_mem[addr] <= wr_data;
        end
        if (wr_en && wr_bank)
        begin
            bank1_mem[addr] <= wr_data;
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule
`default_nettype wire

>>> hdl/dsm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_window
// 3x3 window shift and the four directional three-pixel sums.
// ----------------------------------------------------------------------------
module dsm_window import dsm_pkg::*; #(
    parameter int  PIXEL_BITS = 8,
    localparam int SUM_W      = PIXEL_BITS + 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       s1_valid,
    input  logic                       s1_shift,
    input  tag_t                       s1_tag,
    input  logic                       s1_bank,
    input  logic [PIXEL_BITS-1:0]      s1_pixel,
    input  logic [PIXEL_BITS-1:0]      rd_data0,
    input  logic [PIXEL_BITS-1:0]      rd_data1,
    output logic                       s2_valid,
    output tag_t                       s2_tag,
    output logic [PIXEL_BITS-1:0]      s2_center,
    output logic [3:0][SUM_W-1:0]      s2_sum
);

    logic [8:0][PIXEL_BITS-1:0] win_reg;
    logic [8:0][PIXEL_BITS-1:0] win_next;
    logic [PIXEL_BITS-1:0]      top;
    logic [PIXEL_BITS-1:0]      mid;
    logic                       s2_valid_reg;
    tag_t                       s2_tag_reg;
    logic [PIXEL_BITS-1:0]      s2_center_reg;
    logic [3:0][SUM_W-1:0]      s2_sum_reg;

    function automatic logic [SUM_W-1:0] sum3(input logic [PIXEL_BITS-1:0] a,
                                              input logic [PIXEL_BITS-1:0] b,
                                              input logic [PIXEL_BITS-1:0] c);
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    endfunction

    // bank of the current row holds row-2, the other bank row-1
    always_comb
    begin
        top = s1_bank ? rd_data1 : rd_data0;
        mid = s1_bank ? rd_data0 : rd_data1;
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = s1_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_valid && s1_shift)
            begin
                win_reg <= win_next;
            end
            s2_valid_reg <= s1_valid && s1_tag.emit;
        end
    end

    // tail beats carry the stored pixel straight through as the center
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tag_reg    <= s1_tag;
            s2_center_reg <= s1_tag.tail ? top : win_next[4];
            s2_sum_reg[0] <= sum3(win_next[1], win_next[4], win_next[7]);
            s2_sum_reg[1] <= sum3(win_next[3], win_next[4], win_next[5]);
            s2_sum_reg[2] <= sum3(win_next[0], win_next[4], win_next[8]);
            s2_sum_reg[3] <= sum3(win_next[2], win_next[4], win_next[6]);
        end
    end

    assign s2_valid  = s2_valid_reg;
    assign s2_tag    = s2_tag_reg;
    assign s2_center = s2_center_reg;
    assign s2_sum    = s2_sum_reg;

endmodule
`default_nettype wire

>>> hdl/dsm_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_select
// Divide the sums by three, pick the average closest to the center (border
// pixels keep the center) and register the result beat.
// ----------------------------------------------------------------------------
module dsm_select import dsm_pkg::*; #(
    parameter int  PIXEL_BITS = 8,
    localparam int SUM_W      = PIXEL_BITS + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  s2_valid,
    input  tag_t                  s2_tag,
    input  logic [PIXEL_BITS-1:0] s2_center,
    input  logic [3:0][SUM_W-1:0] s2_sum,
    output logic                  out_valid,
    output logic [PIXEL_BITS-1:0] out_pixel,
    output logic [DIR_W-1:0]      out_dir,
    output logic                  out_last
);

    // floor(x/3) as (x * ceil(2^RSH/3)) >> RSH, exact for x below 2^(RSH-1)
    localparam int                RSH    = SUM_W + 2;
    localparam int                PROD_W = SUM_W + RSH - 1;
    localparam logic [PROD_W-1:0] RECIP  = PROD_W'(((1 << RSH) + 2) / 3);

    logic [3:0][PROD_W-1:0]     prod;
    logic [3:0][PIXEL_BITS-1:0] avg_next;
    logic                       s3_valid_reg;
    tag_t                       s3_tag_reg;
    logic [PIXEL_BITS-1:0]      s3_center_reg;
    logic [3:0][PIXEL_BITS-1:0] s3_avg_reg;
    logic [PIXEL_BITS-1:0]      diff;
    logic [PIXEL_BITS-1:0]      best_diff;
    dir_t                       best_dir;
    logic [PIXEL_BITS-1:0]      best_val;
    dir_t                       sel_dir;
    logic [PIXEL_BITS-1:0]      sel_val;
    logic                       out_valid_reg;
    logic [PIXEL_BITS-1:0]      out_pixel_reg;
    dir_t                       out_dir_reg;
    logic                       out_last_reg;

    function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k]     = PROD_W'(s2_sum[k]) * RECIP;
            avg_next[k] = prod[k][RSH +: PIXEL_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg  <= s2_valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_tag_reg    <= s2_tag;
            s3_center_reg <= s2_center;
            s3_avg_reg    <= avg_next;
            out_pixel_reg <= sel_val;
            out_dir_reg   <= sel_dir;
            out_last_reg  <= s3_tag_reg.last;
        end
    end

    // later direction wins a tie
    always_comb
    begin
        best_diff = abs_diff(s3_center_reg, s3_avg_reg[0]);
        best_dir  = DIR_VERTICAL;
        best_val  = s3_avg_reg[0];
        diff      = '0;
        for (int k = 1; k < 4; k++)
        begin
            diff = abs_diff(s3_center_reg, s3_avg_reg[k]);
            if (diff <= best_diff)
            begin
                best_diff = diff;
                best_dir  = dir_t'(k);
                best_val  = s3_avg_reg[k];
            end
        end
        if (s3_tag_reg.interior)
        begin
            sel_dir = best_dir;
            sel_val = best_val;
        end
        else
        begin
            sel_dir = DIR_BORDER;
            sel_val = s3_center_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_dir   = out_dir_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

>>> hdl/directional_smoothing_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// directional_smoothing_3x3
// Streaming 3x3 directional smoothing: raster counters, line banks, window,
// averaging and selection, one pixel beat per clock while results are not back-pressured.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, limited only by result back-pressure.
// Pipeline: the input beat that completes a result passes the s1, window, average
//   and output registers; results trail the pixels by one row plus one pixel,
//   and width+1 tail beats (flush or not) drain the last row after the frame.
// Reset: counters cleared, frame height 512, width 512 capped at MAX_WIDTH, line banks not cleared
//   (a bank entry is always written in a frame before it reaches a result).
module directional_smoothing_3x3 import dsm_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    dsm_pixel_if.sink    video,
    dsm_result_if.source result,
    dsm_cfg_if.sink      cfg
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > CFG_DATA_W) ? WID_W : CFG_DATA_W;
    localparam int SUM_W = PIXEL_BITS + 2;
    localparam logic [COL_W-1:0] W_LAST_RESET =
        COL_W'(((RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM) - 1);
    localparam logic [ROW_W-1:0] H_LAST_RESET = ROW_W'(RESET_DIM - 1);

    logic [COL_W-1:0]      w_last_reg, w_last_next;
    logic [ROW_W-1:0]      h_last_reg, h_last_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic                  cfg_we;
    logic                  cfg_hit;
    logic                  adv;
    logic                  accept;
    logic                  tail;
    logic                  take_pixel;
    logic                  primed;
    logic                  emit;
    logic                  out_at_last;
    logic                  interior;
    logic                  s1_valid_reg;
    logic                  s1_shift_reg;
    tag_t                  s1_tag_reg;
    logic                  s1_bank_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [COL_W-1:0]      buf_addr;
    logic [PIXEL_BITS-1:0] rd_data0;
    logic [PIXEL_BITS-1:0] rd_data1;
    logic                  s2_valid;
    tag_t                  s2_tag;
    logic [PIXEL_BITS-1:0] s2_center;
    logic [3:0][SUM_W-1:0] s2_sum;
    logic                  res_valid;
    logic [PIXEL_BITS-1:0] res_pixel;
    logic [DIR_W-1:0]      res_dir;
    logic                  res_last;

    function automatic logic [COL_W-1:0] width_last(input logic [CFG_DATA_W-1:0] v);
        logic [CMP_W-1:0] vx;
        logic [CMP_W-1:0] wx;
        vx = CMP_W'(v);
        if (vx < CMP_W'(MIN_DIM))
            wx = CMP_W'(MIN_DIM);
        else if (vx > CMP_W'(MAX_WIDTH))
            wx = CMP_W'(MAX_WIDTH);
        else
            wx = vx;
        return COL_W'(wx - 1'b1);
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] hx;
        if (v < CFG_DATA_W'(MIN_DIM))
            hx = CFG_DATA_W'(MIN_DIM);
        else if (v > CFG_DATA_W'(MAX_HEIGHT))
            hx = CFG_DATA_W'(MAX_HEIGHT);
        else
            hx = v;
        return ROW_W'(hx - 1'b1);
    endfunction

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        cfg_hit     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:
                begin
                    w_last_next = width_last(cfg.data);
                    cfg_hit     = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    h_last_next = height_last(cfg.data);
                    cfg_hit     = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ---------------- input stage ----------------
    assign adv         = !res_valid || result.ready;
    assign video.ready = adv;

    always_comb
    begin
        accept      = video.valid && video.ready;
        tail        = in_row_reg > h_last_reg;
        take_pixel  = accept && !tail && !video.flush;
        primed      = (in_row_reg >= ROW_W'(2))
                      || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        emit        = accept && (tail || (!video.flush && primed));
        out_at_last = (out_row_reg == h_last_reg) && (out_col_reg == w_last_reg);
        interior    = (out_row_reg != '0) && (out_row_reg < h_last_reg)
                      && (out_col_reg != '0) && (out_col_reg < w_last_reg);
        buf_addr    = tail ? out_col_reg : in_col_reg;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take_pixel)
        begin
            if (in_col_reg == w_last_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        if (emit)
        begin
            if (out_col_reg == w_last_reg)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        // frame end or a write to a frame size register starts a new frame
        if ((emit && out_at_last) || cfg_hit)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= W_LAST_RESET;
            h_last_reg   <= H_LAST_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (adv)
            begin
                s1_valid_reg <= take_pixel || (accept && tail);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_shift_reg <= take_pixel;
            s1_tag_reg   <= '{emit: emit, tail: tail, interior: interior,
                              last: out_at_last};
            s1_bank_reg  <= tail ? out_row_reg[0] : in_row_reg[0];
            s1_pixel_reg <= video.pixel_in;
        end
    end

    // ---------------- datapath ----------------
    dsm_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .clk      (clk),
        .rd_en    (accept),
        .addr     (buf_addr),
        .wr_en    (take_pixel),
        .wr_bank  (in_row_reg[0]),
        .wr_data  (video.pixel_in),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    dsm_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s1_valid  (s1_valid_reg),
        .s1_shift  (s1_shift_reg),
        .s1_tag    (s1_tag_reg),
        .s1_bank   (s1_bank_reg),
        .s1_pixel  (s1_pixel_reg),
        .rd_data0  (rd_data0),
        .rd_data1  (rd_data1),
        .s2_valid  (s2_valid),
        .s2_tag    (s2_tag),
        .s2_center (s2_center),
        .s2_sum    (s2_sum)
    );

    dsm_select #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s2_valid  (s2_valid),
        .s2_tag    (s2_tag),
        .s2_center (s2_center),
        .s2_sum    (s2_sum),
        .out_valid (res_valid),
        .out_pixel (res_pixel),
        .out_dir   (res_dir),
        .out_last  (res_last)
    );

    assign result.valid     = res_valid;
    assign result.pixel_out = res_pixel;
    assign result.direction = res_dir;
    assign result.last      = res_last;

    // ---------------- assertions ----------------
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg <= w_last_reg) && (out_col_reg <= w_last_reg))
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_row_reg <= ROW_W'(h_last_reg + 1'b1)) && (out_row_reg <= h_last_reg))
        else $error("row counter beyond frame height");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (in_col_reg == '0) && (in_row_reg == '0)
                    && (out_col_reg == '0) && (out_row_reg == '0))
        else $error("register write did not restart the frame");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_at_last) |=> (in_row_reg == '0) && (out_row_reg == '0)
                                  && (out_col_reg == '0))
        else $error("last beat did not restart the frame");

endmodule
`default_nettype wire
